FILE: design/sqj_pkg.sv
`timescale 1ns / 1ps

package sqj_pkg;

	localparam int SQJ_B_DEPTH = 64;
	localparam int SQJ_MAX_HITS = 64;
	localparam int SQJ_CMD_Q_DEPTH = 2;
	localparam int SQJ_RES_Q_DEPTH = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROBE = 1'b1;

	localparam logic REG_HALF_SIZE = 1'b0;
	localparam logic REG_B_COUNT = 1'b1;

	localparam logic [15:0] HALF_SIZE_RESET = 16'd2560;
	localparam logic [6:0] B_COUNT_RESET = 7'd0;

	typedef struct packed {
		logic signed [31:0] x_min;
		logic signed [31:0] y_min;
		logic signed [31:0] x_max;
		logic signed [31:0] y_max;
	} rect_t;

	typedef struct packed {
		logic        probe;
		logic [6:0]  n;
		logic [5:0]  idx;
		rect_t       rect;
	} item_t;

	typedef struct packed {
		logic [5:0]  a_index;
		logic [5:0]  b_index;
		rect_t       over;
		logic [6:0]  hit_count;
		logic        last_hit;
	} result_t;

endpackage

FILE: design/square_pair_intersection_join.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Beat
// input     in         push / full      opcode, entry_index, rect_x/y_min/max
// result    out        pop / empty      a_index, b_index, over_*, hit_count, last_hit
// config    in         cfg_we           cfg_index, cfg_data (half_size, b_count)
//
// A load in the back end is a write to the entry store.
// A probe walks n entries, n being b_count limited to the store depth and to 64: the store's
// read port delivers one entry per cycle unless a full result queue halts the walk, then the
// compare pipe drains.
// Reset loads the configuration defaults and clears all control state; store contents stay
// undefined. A full result queue halts the walk in place; a full command queue raises full.

module square_pair_intersection_join
	import sqj_pkg::*;
#(
	parameter int B_DEPTH = SQJ_B_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic [5:0]         entry_index,
	input  logic signed [31:0] rect_x_min,
	input  logic signed [31:0] rect_y_min,
	input  logic signed [31:0] rect_x_max,
	input  logic signed [31:0] rect_y_max,
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         a_index,
	output logic [5:0]         b_index,
	output logic signed [31:0] over_x_min,
	output logic signed [31:0] over_y_min,
	output logic signed [31:0] over_x_max,
	output logic signed [31:0] over_y_max,
	output logic [6:0]         hit_count,
	output logic               last_hit,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [15:0] half_size_q;
	logic [6:0]  b_count_q;
	rect_t       in_rect;
	logic        cq_push;
	item_t       cq_wdata;
	logic        cq_full;
	logic        cq_pop;
	logic [$bits(item_t)-1:0] cq_rdata;
	logic        cq_empty;
	result_t     res_wdata;
	logic        res_push;
	logic        res_full;
	logic [$bits(result_t)-1:0] res_rdata;
	result_t     res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= HALF_SIZE_RESET;
			b_count_q   <= B_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_SIZE: half_size_q <= cfg_data;
				REG_B_COUNT:   b_count_q   <= cfg_data[6:0];
				default:       half_size_q <= half_size_q;
			endcase
		end
	end

	always_comb begin
		in_rect.x_min = rect_x_min;
		in_rect.y_min = rect_y_min;
		in_rect.x_max = rect_x_max;
		in_rect.y_max = rect_y_max;
	end

	sqj_front #(
		.B_DEPTH(B_DEPTH)
	) u_front (
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.entry_index(entry_index),
		.rect       (in_rect),
		.b_count    (b_count_q),
		.q_push     (cq_push),
		.q_item     (cq_wdata),
		.q_full     (cq_full)
	);

	sqj_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(SQJ_CMD_Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.wdata (cq_wdata),
		.full  (cq_full),
		.pop   (cq_pop),
		.rdata (cq_rdata),
		.empty (cq_empty)
	);

	sqj_back #(
		.B_DEPTH(B_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_t'(cq_rdata)),
		.item_empty(cq_empty),
		.item_pop  (cq_pop),
		.half_size (half_size_q),
		.res       (res_wdata),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	sqj_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(SQJ_RES_Q_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_wdata),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out    = result_t'(res_rdata);
	assign a_index    = res_out.a_index;
	assign b_index    = res_out.b_index;
	assign over_x_min = res_out.over.x_min;
	assign over_y_min = res_out.over.y_min;
	assign over_x_max = res_out.over.x_max;
	assign over_y_max = res_out.over.y_max;
	assign hit_count  = res_out.hit_count;
	assign last_hit   = res_out.last_hit;

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_full) |=> (res_push && $stable(res_wdata)))
		else $error("blocked result changed before it was taken");

	a_last_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_hit) |-> (hit_count != 7'd0))
		else $error("final result carries a zero hit count");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_hit) |=>
		(empty || (hit_count == 7'($past(hit_count) + 7'd1))))
		else $error("hit count did not step by one within a probe");

endmodule

FILE: design/sqj_ram.sv
`timescale 1ns / 1ps

module sqj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/sqj_fifo.sv
`timescale 1ns / 1ps

module sqj_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

FILE: design/sqj_front.sv
`timescale 1ns / 1ps

module sqj_front
	import sqj_pkg::*;
#(
	parameter int B_DEPTH = SQJ_B_DEPTH
) (
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [5:0]  entry_index,
	input  rect_t       rect,
	input  logic [6:0]  b_count,
	output logic        q_push,
	output item_t       q_item,
	input  logic        q_full
);

	localparam int N_MAX = B_DEPTH < SQJ_MAX_HITS ? B_DEPTH : SQJ_MAX_HITS;

	logic [6:0] n_sat;
	logic       keep;

	// Loads outside the store and probes over an empty set do nothing and are dropped here.
	always_comb begin
		n_sat = (b_count > 7'(N_MAX)) ? 7'(N_MAX) : b_count;
		if (opcode == OP_LOAD) begin
			keep = (32'(entry_index) < B_DEPTH);
		end else begin
			keep = (n_sat != '0);
		end
	end

	assign full = q_full;
	assign q_push = push && !q_full && keep;

	always_comb begin
		q_item.probe = (opcode == OP_PROBE);
		q_item.n     = n_sat;
		q_item.idx   = entry_index;
		q_item.rect  = rect;
	end

endmodule

FILE: design/sqj_back.sv
`timescale 1ns / 1ps

module sqj_back
	import sqj_pkg::*;
#(
	parameter int B_DEPTH = SQJ_B_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_empty,
	output logic        item_pop,
	input  logic [15:0] half_size,
	output result_t     res,
	output logic        res_push,
	input  logic        res_full
);

	localparam int AW = B_DEPTH > 1 ? $clog2(B_DEPTH) : 1;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_WALK = 2'b10
	} back_state_t;

	back_state_t state_q;
	item_t       probe_q;
	logic [5:0]  j_q;
	logic [6:0]  hits_q;

	logic        v_s1;
	logic [5:0]  j_s1;
	logic        last_s1;
	logic        v_s2;
	logic [5:0]  j_s2;
	logic        last_s2;
	logic signed [33:0] dx_s2;
	logic signed [33:0] dy_s2;
	rect_t       ov_s2;

	result_t     pend_q;
	logic        pend_v_q;
	logic        pend_fin_q;

	logic        drained;
	logic        take;
	logic        adv;
	logic        issue;
	logic        last_issue;
	logic [127:0] ram_rdata;
	rect_t       b_s1;
	rect_t       a_r;
	logic signed [33:0] bound;
	logic signed [33:0] neg_bound;
	logic        hit;
	logic        push_last;
	result_t     cur;

	assign drained  = !v_s1 && !v_s2 && !pend_v_q;
	assign take     = (state_q == BK_IDLE) && drained && !item_empty;
	assign item_pop = take;
	assign issue    = (state_q == BK_WALK) && adv;
	assign last_issue = ({1'b0, j_q} == (probe_q.n - 7'd1));

	sqj_ram #(
		.WIDTH(128),
		.DEPTH(B_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (take && !item.probe),
		.waddr(AW'(item.idx)),
		.wdata(item.rect),
		.re   (issue),
		.raddr(AW'(j_q)),
		.rdata(ram_rdata)
	);

	assign b_s1 = rect_t'(ram_rdata);
	assign a_r  = probe_q.rect;

	always_comb begin
		bound     = $signed({17'd0, half_size, 1'b0});
		neg_bound = -bound;
		hit = v_s2 && (dx_s2 < bound) && (dx_s2 > neg_bound) &&
			(dy_s2 < bound) && (dy_s2 > neg_bound) &&
			($signed(ov_s2.x_min) < $signed(ov_s2.x_max)) &&
			($signed(ov_s2.y_min) < $signed(ov_s2.y_max));
	end

	// A hit is held back until the next hit or the end of the walk tells whether it is the last.
	always_comb begin
		res_push  = 1'b0;
		push_last = 1'b0;
		if (pend_fin_q) begin
			res_push  = 1'b1;
			push_last = 1'b1;
		end else if (v_s2 && hit && pend_v_q) begin
			res_push = 1'b1;
		end else if (v_s2 && !hit && last_s2 && pend_v_q) begin
			res_push  = 1'b1;
			push_last = 1'b1;
		end
		adv = !(res_push && res_full);
	end

	always_comb begin
		res          = pend_q;
		res.last_hit = push_last;
		cur.a_index   = probe_q.idx;
		cur.b_index   = j_s2;
		cur.over      = ov_s2;
		cur.hit_count = hits_q + 7'd1;
		cur.last_hit  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			j_q        <= '0;
			hits_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			last_s1    <= 1'b0;
			last_s2    <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (take && item.probe) begin
						state_q <= BK_WALK;
						j_q     <= '0;
						hits_q  <= '0;
					end
				end
				BK_WALK: begin
					if (issue) begin
						if (last_issue) begin
							state_q <= BK_IDLE;
						end else begin
							j_q <= j_q + 6'd1;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (adv) begin
				v_s1    <= issue;
				last_s1 <= last_issue;
				v_s2    <= v_s1;
				last_s2 <= last_s1;
				if (pend_fin_q) begin
					pend_v_q   <= 1'b0;
					pend_fin_q <= 1'b0;
				end else if (v_s2) begin
					if (hit) begin
						pend_v_q   <= 1'b1;
						pend_fin_q <= last_s2;
						hits_q     <= hits_q + 7'd1;
					end else if (last_s2) begin
						pend_v_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.probe) begin
			probe_q <= item;
		end
		if (adv) begin
			j_s1  <= j_q;
			j_s2  <= j_s1;
			dx_s2 <= $signed({{2{a_r.x_min[31]}}, a_r.x_min}) -
				$signed({{2{b_s1.x_min[31]}}, b_s1.x_min});
			dy_s2 <= $signed({{2{a_r.y_min[31]}}, a_r.y_min}) -
				$signed({{2{b_s1.y_min[31]}}, b_s1.y_min});
			ov_s2.x_min <= ($signed(a_r.x_min) > $signed(b_s1.x_min)) ? a_r.x_min : b_s1.x_min;
			ov_s2.y_min <= ($signed(a_r.y_min) > $signed(b_s1.y_min)) ? a_r.y_min : b_s1.y_min;
			ov_s2.x_max <= ($signed(a_r.x_max) < $signed(b_s1.x_max)) ? a_r.x_max : b_s1.x_max;
			ov_s2.y_max <= ($signed(a_r.y_max) < $signed(b_s1.y_max)) ? a_r.y_max : b_s1.y_max;
			if (!pend_fin_q && v_s2 && hit) begin
				pend_q <= cur;
			end
		end
	end

endmodule

FILE: tb/square_pair_intersection_join_tb.sv
`timescale 1ns / 1ps

module square_pair_intersection_join_tb;
	import sqj_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 4 * (SQJ_B_DEPTH + 3);
	localparam int unsigned SPREAD = 4096;
	localparam logic [31:0] EDGE_MIN = 32'h8000_0000;
	localparam logic [31:0] EDGE_MAX = 32'h7FFF_FFFF;
	localparam longint CENTER_HIGH = 64'sd2147483647 - 2 * SPREAD;
	localparam longint CENTER_LOW = -64'sd2147483648;

	typedef struct packed {
		logic       opcode;
		logic [5:0] entry_index;
		rect_t      rect;
	} cmd_t;

	class overlap_scoreboard;
		logic [15:0] square_half;
		logic [6:0] walk_len;
		rect_t stored[SQJ_B_DEPTH];
		result_t expected_overlaps[$];
		int unsigned errors;

		function new();
			square_half = HALF_SIZE_RESET;
			walk_len = B_COUNT_RESET;
			errors = 0;
			foreach (stored[i])
				stored[i] = '0;
		endfunction

		function longint abs_diff(longint a, longint b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void add_expected(result_t r);
			expected_overlaps = {expected_overlaps, r};
		endfunction

		function void note_input(cmd_t c);
			longint bound;
			longint ax0, ay0, ax1, ay1;
			longint bx0, by0, bx1, by1;
			longint ox0, oy0, ox1, oy1;
			int unsigned walk;
			int unsigned hits;
			bit have_held;
			result_t held;
			if (c.opcode == OP_LOAD) begin
				stored[c.entry_index] = c.rect;
				return;
			end
			walk = (walk_len > SQJ_B_DEPTH) ? SQJ_B_DEPTH : walk_len;
			if (walk > SQJ_MAX_HITS)
				walk = SQJ_MAX_HITS;
			bound = 2 * longint'(square_half);
			ax0 = longint'($signed(c.rect.x_min));
			ay0 = longint'($signed(c.rect.y_min));
			ax1 = longint'($signed(c.rect.x_max));
			ay1 = longint'($signed(c.rect.y_max));
			hits = 0;
			have_held = 1'b0;
			for (int j = 0; j < walk; j++) begin
				bx0 = longint'($signed(stored[j].x_min));
				by0 = longint'($signed(stored[j].y_min));
				bx1 = longint'($signed(stored[j].x_max));
				by1 = longint'($signed(stored[j].y_max));
				if (abs_diff(ax0, bx0) >= bound || abs_diff(ay0, by0) >= bound)
					continue;
				ox0 = (ax0 > bx0) ? ax0 : bx0;
				oy0 = (ay0 > by0) ? ay0 : by0;
				ox1 = (ax1 < bx1) ? ax1 : bx1;
				oy1 = (ay1 < by1) ? ay1 : by1;
				if (!(ox0 < ox1 && oy0 < oy1))
					continue;
				if (have_held)
					add_expected(held);
				held.a_index = c.entry_index;
				held.b_index = 6'(j);
				held.over.x_min = ox0[31:0];
				held.over.y_min = oy0[31:0];
				held.over.x_max = ox1[31:0];
				held.over.y_max = oy1[31:0];
				held.hit_count = 7'(hits + 1);
				held.last_hit = 1'b0;
				have_held = 1'b1;
				hits++;
			end
			if (have_held) begin
				held.last_hit = 1'b1;
				add_expected(held);
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_overlaps.size() == 0) begin
				$error("unexpected result: a_index %0d b_index %0d", got.a_index, got.b_index);
				errors++;
				return;
			end
			want = expected_overlaps.pop_front();
			compare("a_index", want.a_index, got.a_index);
			compare("b_index", want.b_index, got.b_index);
			compare("over_x_min", want.over.x_min, got.over.x_min);
			compare("over_y_min", want.over.y_min, got.over.y_min);
			compare("over_x_max", want.over.x_max, got.over.x_max);
			compare("over_y_max", want.over.y_max, got.over.y_max);
			compare("hit_count", want.hit_count, got.hit_count);
			compare("last_hit", want.last_hit, got.last_hit);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic opcode = OP_LOAD;
	logic [5:0] entry_index = '0;
	logic signed [31:0] rect_x_min = '0;
	logic signed [31:0] rect_y_min = '0;
	logic signed [31:0] rect_x_max = '0;
	logic signed [31:0] rect_y_max = '0;
	logic empty;
	logic pop = 1'b0;
	logic [5:0] a_index;
	logic [5:0] b_index;
	logic signed [31:0] over_x_min;
	logic signed [31:0] over_y_min;
	logic signed [31:0] over_x_max;
	logic signed [31:0] over_y_max;
	logic [6:0] hit_count;
	logic last_hit;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_HALF_SIZE;
	logic [15:0] cfg_data = '0;

	overlap_scoreboard sb;
	int unsigned tx_max_gap = 18;
	int unsigned rx_max_gap = 18;
	int unsigned rx_hold = 0;
	longint cluster_center = 0;

	square_pair_intersection_join dut (.*);

	always #4 clk = ~clk;

	function automatic rect_t box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
			logic [31:0] y1);
		return {x0, y0, x1, y1};
	endfunction

	function automatic cmd_t make_cmd(logic op, logic [5:0] idx, rect_t r);
		cmd_t c;
		c.opcode = op;
		c.entry_index = idx;
		c.rect = r;
		return c;
	endfunction

	function automatic rect_t cluster_rect();
		longint x0, y0, x1, y1;
		x0 = cluster_center + longint'($urandom_range(0, SPREAD));
		x1 = x0 + longint'($urandom_range(0, SPREAD));
		y0 = cluster_center + longint'($urandom_range(0, SPREAD));
		y1 = y0 + longint'($urandom_range(0, SPREAD));
		if ($urandom_range(0, 15) == 0)
			return box(x1[31:0], y1[31:0], x0[31:0], y0[31:0]);
		return box(x0[31:0], y0[31:0], x1[31:0], y1[31:0]);
	endfunction

	function automatic cmd_t random_cmd();
		if ($urandom_range(0, 9) == 0)
			return make_cmd(1'($urandom), 6'($urandom), box($urandom, $urandom, $urandom,
				$urandom));
		return make_cmd(($urandom_range(0, 2) == 0) ? OP_LOAD : OP_PROBE, 6'($urandom),
			cluster_rect());
	endfunction

	task automatic send_cmd(input cmd_t c);
		int unsigned gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= c.opcode;
		entry_index <= c.entry_index;
		rect_x_min <= c.rect.x_min;
		rect_y_min <= c.rect.y_min;
		rect_x_max <= c.rect.x_max;
		rect_y_max <= c.rect.y_max;
		do
			@(posedge clk);
		while (full);
		sb.note_input(c);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.expected_overlaps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] half, input logic [6:0] count);
		cfg_we <= 1'b1;
		cfg_index <= REG_HALF_SIZE;
		cfg_data <= half;
		@(posedge clk);
		cfg_index <= REG_B_COUNT;
		cfg_data <= {9'd0, count};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.square_half = half;
		sb.walk_len = count;
	endtask

	task automatic run_phase(input logic [15:0] half, input logic [6:0] count,
			input longint center, input int unsigned tx_gap, input int unsigned rx_gap,
			input int unsigned hold, input int unsigned items);
		settle();
		write_config(half, count);
		cluster_center = center;
		tx_max_gap = tx_gap;
		rx_max_gap = rx_gap;
		rx_hold = hold;
		repeat (items) send_cmd(random_cmd());
	endtask

	initial begin : stimulus
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(HALF_SIZE_RESET, 7'd4);
		send_cmd(make_cmd(OP_LOAD, 6'd0, box(32'sd0, 32'sd0, 32'sd2560, 32'sd2560)));
		send_cmd(make_cmd(OP_LOAD, 6'd1, box(32'sd5120, 32'sd0, 32'sd7680, 32'sd2560)));
		send_cmd(make_cmd(OP_LOAD, 6'd2, box(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX)));
		send_cmd(make_cmd(OP_LOAD, 6'd3, box(32'sd2560, 32'sd2560, 32'sd0, 32'sd0)));
		send_cmd(make_cmd(OP_PROBE, 6'd0, box(32'sd0, 32'sd0, 32'sd2560, 32'sd2560)));
		send_cmd(make_cmd(OP_PROBE, 6'd63, box(32'sd2560, 32'sd0, 32'sd5120, 32'sd2560)));
		send_cmd(make_cmd(OP_PROBE, 6'd42, box(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX)));
		send_cmd(make_cmd(OP_PROBE, 6'd21, box(EDGE_MAX, EDGE_MIN, EDGE_MIN, EDGE_MAX)));
		send_cmd(make_cmd(OP_PROBE, 6'd1, box(32'sd2560, 32'sd2560, 32'sd0, 32'sd0)));
		send_cmd(make_cmd(OP_PROBE, 6'd5, box(32'sd100, 32'sd200, 32'sd9000, 32'sd9000)));
		send_cmd(make_cmd(OP_PROBE, 6'd6, box(-32'sd3000, -32'sd3000, 32'sd1000,
			32'sd1000)));
		send_cmd(make_cmd(OP_LOAD, 6'd1, box(-32'sd2560, -32'sd2560, -32'sd1, -32'sd1)));
		send_cmd(make_cmd(OP_PROBE, 6'd7, box(-32'sd2000, -32'sd2000, -32'sd500,
			-32'sd500)));
		send_cmd(make_cmd(OP_LOAD, 6'd63, box(EDGE_MAX, EDGE_MAX, EDGE_MIN, EDGE_MIN)));

		// Every entry is written here, before any probe walks past the first four.
		settle();
		write_config(16'hFFFF, 7'd0);
		for (int i = 0; i < SQJ_B_DEPTH; i++) begin
			send_cmd(make_cmd(OP_LOAD, 6'(i), cluster_rect()));
			if (i % 8 == 7)
				send_cmd(make_cmd(OP_PROBE, 6'($urandom), cluster_rect()));
		end

		run_phase(HALF_SIZE_RESET, 7'd64, 0, 18, 18, 0, 24);
		run_phase(16'd0, 7'd37, 0, 5, 18, 0, 12);
		run_phase(16'hFFFF, 7'd127, CENTER_HIGH, 0, 0, 0, 24);
		run_phase(16'd3000, 7'd64, 0, 0, 18, 500, 24);
		run_phase(16'd300, 7'd1, CENTER_LOW, 18, 0, 0, 24);
		run_phase(16'($urandom_range(0, 65535)), 7'($urandom_range(1, 64)), 0,
			$urandom_range(0, 18), $urandom_range(0, 18), 0, 30);
		settle();

		if (sb.errors == 0 && sb.expected_overlaps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : result_sink
		int unsigned idle_left;
		result_t got;
		idle_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {a_index, b_index, over_x_min, over_y_min, over_x_max, over_y_max,
					hit_count, last_hit};
				sb.check_result(got);
				idle_left = $urandom_range(0, rx_max_gap);
			end else if (idle_left > 0) begin
				idle_left--;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				pop <= (idle_left == 0);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$error("no beat accepted for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
design/sqj_pkg.sv
design/sqj_ram.sv
design/sqj_fifo.sv
design/sqj_front.sv
design/sqj_back.sv
design/square_pair_intersection_join.sv
tb/square_pair_intersection_join_tb.sv
